>>> rtl/address_binding_table_top_defines.svh
// Assertion macros for the address binding table.
`ifndef ADDRESS_BINDING_TABLE_TOP_DEFINES_SVH
`define ADDRESS_BINDING_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define ABT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("address binding table check failed");
// Checks that a condition never holds outside reset.
`define ABT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("address binding table forbidden condition");
`else
`define ABT_ASSERT(lbl, clk, rst, prop)
`define ABT_NEVER(lbl, clk, rst, cond)
`endif

`endif

>>> rtl/abt_pkg.sv
// Shared types and constants for the address binding table.
package abt_pkg;

  // Default number of table entries.
  localparam int TableDepthDefault = 16;
  // Driver numbers at or above this count are rejected by a bind.
  localparam int DriverSlots = 16;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_BIND   = 2'd1,
    CMD_UNBIND = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  // One stored table entry.
  typedef struct packed {
    logic [15:0] key;
    logic [3:0]  drv;
  } entry_t;

endpackage

>>> rtl/abt_req_if.sv
// Request channel carrying one table command item.
interface abt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] device_addr;
  logic        driver_given;
  logic [3:0]  driver_num;

  modport source (output valid, command, device_addr, driver_given, driver_num,
                  input ready);
  modport sink (input valid, command, device_addr, driver_given, driver_num,
                output ready);
endinterface

>>> rtl/abt_rsp_if.sv
// Response channel carrying one table result item.
interface abt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;
  logic [3:0] bound_driver;

  modport source (output valid, status, found, bound_driver, input ready);
  modport sink (input valid, status, found, bound_driver, output ready);
endinterface

>>> rtl/abt_mem.sv
// Entry memory: one write port and one read port with registered read data.
module abt_mem import abt_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/abt_ctrl.sv
// Sequencer: scans the entry memory, applies the command and issues the result.
module abt_ctrl import abt_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  abt_req_if.sink       req,
  abt_rsp_if.source     rsp,
  output logic          rd_en,
  output logic [IW-1:0] rd_addr,
  input  entry_t        rd_data,
  output logic          wr_en,
  output logic [IW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic [CW-1:0] count
);

  localparam logic [CW-1:0] DepthVal = CW'(TABLE_DEPTH);
  localparam logic [8:0]    SlotLimit = 9'(DriverSlots);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_RDLAST, S_MOVE, S_DONE
  } state_t;

  state_t        state;
  cmd_t          cmd;
  logic [15:0]   addr;
  logic [3:0]    drv;
  logic [CW-1:0] scan_idx;
  logic          chk_valid;
  logic [IW-1:0] chk_idx;
  logic          hit;
  logic [IW-1:0] slot;
  logic [3:0]    hit_drv;
  status_t       res_status;
  logic          res_found;
  logic [3:0]    res_drv;

  logic          match;
  logic          more;
  logic [CW-1:0] last;
  logic          bind_bad;
  logic          need_move;

  // Compare the entry read last cycle and decide whether to read another.
  assign match    = chk_valid && (rd_data.key == addr);
  assign more     = scan_idx < count;
  assign last     = count - CW'(1);
  assign bind_bad = !req.driver_given || ({5'b0, req.driver_num} >= SlotLimit);
  assign req.ready = (state == S_IDLE);

  // A hit below the last entry is filled by moving the last one in.
  assign need_move = hit && ((CW'(slot) + CW'(1)) < count);

  // Memory port drive.
  always_comb begin
    rd_en   = ((state == S_SCAN) && !match && more) || (state == S_RDLAST);
    rd_addr = (state == S_RDLAST) ? last[IW-1:0] : scan_idx[IW-1:0];
    wr_en   = ((state == S_ACT) && (cmd == CMD_BIND) && (hit || (count != DepthVal)))
              || (state == S_MOVE);
    if (state == S_MOVE) begin
      wr_addr = slot;
      wr_data = rd_data;
    end else begin
      wr_addr = hit ? slot : count[IW-1:0];
      wr_data = '{key: addr, drv: drv};
    end
  end

  // Command sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd        <= cmd_t'(req.command);
            addr       <= req.device_addr;
            drv        <= req.driver_num;
            scan_idx   <= '0;
            chk_valid  <= 1'b0;
            hit        <= 1'b0;
            res_found  <= 1'b0;
            res_drv    <= '0;
            if (cmd_t'(req.command) == CMD_NOP) begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end else if ((cmd_t'(req.command) == CMD_BIND) && bind_bad) begin
              res_status <= ST_INVALID;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            hit     <= 1'b1;
            slot    <= chk_idx;
            hit_drv <= rd_data.drv;
            state   <= S_ACT;
          end else if (more) begin
            chk_valid <= 1'b1;
            chk_idx   <= scan_idx[IW-1:0];
            scan_idx  <= scan_idx + CW'(1);
          end else begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          state <= ((cmd == CMD_UNBIND) && need_move) ? S_RDLAST : S_DONE;
          case (cmd)
            CMD_LOOKUP: begin
              res_found <= hit;
              res_drv   <= hit ? hit_drv : 4'd0;
            end
            CMD_BIND: begin
              if (!hit) begin
                if (count == DepthVal) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
            end
            CMD_UNBIND: begin
              // A hit on the last entry just shrinks the count.
              if (hit && !need_move) begin
                count <= last;
              end
            end
            default: begin
            end
          endcase
        end
        S_RDLAST: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          count <= last;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.found        <= res_found;
            rsp.bound_driver <= res_drv;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/address_binding_table_top.sv
// Address binding table: lookup, bind and unbind of address to driver pairs.
//
// The req channel takes one command item (lookup, bind or update, unbind)
// with a 16-bit device address and a driver number. The rsp channel returns
// exactly one result item per command: a status, a found flag and the bound
// driver for lookups. Both channels handshake on valid and ready.
// Entries live in one memory with a registered read. A command is
// handled one at a time: the table is scanned one entry per cycle from the
// first entry until a match or, on a miss, through all stored entries. An
// unbind that moves the last entry into the freed slot adds a read of the
// last entry and a write into that slot. Command code 3 and a rejected bind
// skip the scan and go straight to the result.
// Reset clears the entry count; the memory itself is not cleared, since
// entries at or above the count are never read.
// When the receiver stalls, the finished result waits in the output register
// and the next item is still accepted; its result waits until that register
// is free.
`include "address_binding_table_top_defines.svh"

module address_binding_table_top import abt_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input logic       clk,
  input logic       rst,
  abt_req_if.sink   req,
  abt_rsp_if.source rsp
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [CW-1:0] count;

  // Command sequencer.
  abt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .count   (count)
  );

  // Entry storage.
  abt_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // The count never passes the table depth.
  `ABT_ASSERT(a_count_max, clk, rst, count <= CW'(TABLE_DEPTH))
  // Writes land inside the table or at the append position.
  `ABT_ASSERT(a_wr_in_range, clk, rst, wr_en |-> (CW'(wr_addr) <= count))
  // No memory write while a new item is being taken.
  `ABT_NEVER(a_wr_idle, clk, rst, wr_en && req.valid && req.ready)
  // Right after an item is accepted the block is busy and not ready.
  `ABT_ASSERT(a_busy_after_accept, clk, rst, (req.valid && req.ready) |=> !req.ready)

endmodule
